/* rtl/core/cbc_pkg.sv */
// Shared constants, types and state codes of the colour blob centroid core.
package cbc_pkg;

  localparam int COLOR_W = 8;
  localparam int COORD_W = 10;
  localparam int RATIO_W = 4;
  localparam int PROD_W  = RATIO_W + COLOR_W;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd5;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  typedef enum logic [1:0] {
    S_ACC,
    S_DIV_X,
    S_DIV_Y,
    S_DONE
  } cbc_state_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
  } div_stat_t;

endpackage

/* rtl/core/cbc_pixel_if.sv */
// Pixel input channel.
interface cbc_pixel_if
  import cbc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               last_pixel;

  modport source (output valid, red, green, blue, col, row, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, col, row, last_pixel, output ready);
endinterface

/* rtl/core/cbc_result_if.sv */
// Centroid result channel.
interface cbc_result_if
  import cbc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               found;
  logic [COORD_W-1:0] centroid_x;
  logic [COORD_W-1:0] centroid_y;

  modport source (output valid, found, centroid_x, centroid_y, input ready);
  modport sink   (input valid, found, centroid_x, centroid_y, output ready);
endinterface

/* rtl/core/cbc_cfg_if.sv */
// Configuration write channel for the dominance ratio.
interface cbc_cfg_if
  import cbc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/color_blob_centroid_core.sv */
// Top level: colour threshold, centroid accumulation and per-frame mean.
//
//   channel  dir  payload                          accepted when
//   pixel    in   red green blue col row last_pix  pixel.valid & pixel.ready
//   result   out  found centroid_x centroid_y      result.valid & result.ready
//   cfg      in   data (dominance ratio, 4 bits)   cfg.valid & cfg.ready
//
// While the core accumulates, pixel.ready is high, so a pixel that is not last of its frame is never stalled.
// After the last pixel, pixel.ready stays low while the shared restoring divider
// runs 10 steps for the column mean and 10 for the row mean, until the result loads.
// The result sits in an output register; a stalled result holds only the final
// write stage. Synchronous reset clears the sums, count, ratio (to 5) and state.
module color_blob_centroid_core
  import cbc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst,
  cbc_pixel_if.sink    pixel,
  cbc_result_if.source result,
  cbc_cfg_if.sink      cfg
);

  localparam int HIT_CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_W   = $clog2(HIT_CAP + 1);
  localparam int SUM_W   = CNT_W + COORD_W;
  localparam logic [CNT_W-1:0] HIT_CAP_C = CNT_W'(HIT_CAP);

  cbc_state_t         state, state_next;
  logic [RATIO_W-1:0] ratio;
  logic [SUM_W-1:0]   col_sum, col_sum_next;
  logic [SUM_W-1:0]   row_sum, row_sum_next;
  logic [CNT_W-1:0]   hit_count, hit_count_next;
  logic [COORD_W-1:0] qx;
  logic [PROD_W-1:0]  prod_r, prod_g;
  logic               hit, take, accept;
  logic               div_start;
  logic [SUM_W-1:0]   div_dividend;
  logic [CNT_W-1:0]   div_divisor;
  div_stat_t          div_stat;
  logic               load_out, capture_x;
  logic               res_valid;
  logic               res_found;
  logic [COORD_W-1:0] res_x, res_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
    end else if (cfg.valid) begin
      ratio <= cfg.data;
    end
  end

  assign prod_r = PROD_W'(ratio) * PROD_W'(pixel.red);
  assign prod_g = PROD_W'(ratio) * PROD_W'(pixel.green);
  assign hit    = (PROD_W'(pixel.blue) > prod_r) && (PROD_W'(pixel.blue) > prod_g);
  assign take   = hit && (hit_count < HIT_CAP_C);
  assign accept = pixel.valid && pixel.ready;

  assign col_sum_next   = take ? col_sum + SUM_W'(pixel.col) : col_sum;
  assign row_sum_next   = take ? row_sum + SUM_W'(pixel.row) : row_sum;
  assign hit_count_next = take ? hit_count + 1'b1 : hit_count;

  always_comb begin
    state_next   = state;
    pixel.ready  = 1'b0;
    div_start    = 1'b0;
    div_dividend = col_sum_next;
    div_divisor  = hit_count_next;
    load_out     = 1'b0;
    capture_x    = 1'b0;
    unique case (state)
      S_ACC: begin
        pixel.ready = 1'b1;
        if (pixel.valid && pixel.last_pixel) begin
          div_start  = 1'b1;
          state_next = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (div_stat.done) begin
          capture_x    = 1'b1;
          div_start    = 1'b1;
          div_dividend = row_sum;
          div_divisor  = hit_count;
          state_next   = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      col_sum   <= '0;
      row_sum   <= '0;
      hit_count <= '0;
    end else if (accept) begin
      col_sum   <= col_sum_next;
      row_sum   <= row_sum_next;
      hit_count <= hit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (capture_x) begin
      qx <= div_stat.quot;
    end
  end

  cbc_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_found <= (hit_count != '0);
      res_x     <= (hit_count != '0) ? qx : '0;
      res_y     <= (hit_count != '0) ? div_stat.quot : '0;
    end
  end

  assign result.valid      = res_valid;
  assign result.found      = res_found;
  assign result.centroid_x = res_x;
  assign result.centroid_y = res_y;

endmodule

/* rtl/core/cbc_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module cbc_div
  import cbc_pkg::*;
#(
  parameter int CNT_W = 21,
  parameter int SUM_W = CNT_W + COORD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output div_stat_t        stat
);

  localparam int DSH_W  = CNT_W + COORD_W - 1;
  localparam int STEP_W = $clog2(COORD_W);

  logic [SUM_W-1:0]   rem;
  logic [DSH_W-1:0]   dsh;
  logic [COORD_W-1:0] q;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;
  logic [SUM_W:0]     trial;

  assign trial = {1'b0, rem} - (SUM_W + 1)'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(COORD_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= {divisor, {(COORD_W - 1){1'b0}}};
    end else if (busy) begin
      if (!trial[SUM_W]) begin
        rem <= trial[SUM_W-1:0];
      end
      q   <= {q[COORD_W-2:0], ~trial[SUM_W]};
      dsh <= dsh >> 1;
    end
  end

  assign stat.done = done;
  assign stat.quot = q;

endmodule

/* rtl/core/cbc_checker.sv */
// Port-level assertions for the colour blob centroid core, with its bind.
module cbc_checker
  import cbc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               pixel_valid,
  input logic               pixel_ready,
  input logic               pixel_last,
  input logic               result_valid,
  input logic               result_ready,
  input logic               result_found,
  input logic [COORD_W-1:0] result_x,
  input logic [COORD_W-1:0] result_y
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_found)
      && $stable(result_x) && $stable(result_y))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_found |-> result_x == '0 && result_y == '0)
    else $error("frame without hits gave non-zero centroid");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && pixel_last |=> !pixel_ready)
    else $error("pixel taken straight after last pixel");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!pixel_ready))
    else $error("result appeared without a frame end");

endmodule

bind color_blob_centroid_core cbc_checker u_cbc_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel.valid),
  .pixel_ready  (pixel.ready),
  .pixel_last   (pixel.last_pixel),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_found (result.found),
  .result_x     (result.centroid_x),
  .result_y     (result.centroid_y)
);
